// File: rtl/core/rect_distinct_color_count_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle distinct-color counter
// Clocked implication checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef RECT_DISTINCT_COLOR_COUNT_UNIT_ASSERT_SVH
`define RECT_DISTINCT_COLOR_COUNT_UNIT_ASSERT_SVH

// same-cycle implication
`define RDCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rdcc_pkg.sv
// ----------------------------------------------------------------------------
// rdcc_pkg
// Sizes, command codes and shared types of the distinct-color counter.
// ----------------------------------------------------------------------------
package rdcc_pkg;

    localparam int MAX_POINTS     = 256;
    localparam int COORD_BITS     = 16;
    localparam int COLOR_BITS     = 16;
    localparam int FIELD_BITS     = 16;
    localparam int OUT_COUNT_BITS = 9;
    localparam int IDX_BITS       = $clog2(MAX_POINTS);
    localparam int CNT_BITS       = IDX_BITS + 1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        t_entry              wdata;
        logic                re;
        logic [IDX_BITS-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic                      valid;
        logic [OUT_COUNT_BITS-1:0] count;
        logic                      status;
    } t_result;

    typedef struct packed {
        logic                busy;
        logic [CNT_BITS-1:0] count;
    } t_seq_stat;

endpackage

// File: rtl/core/rdcc_in_if.sv
// ----------------------------------------------------------------------------
// rdcc_in_if
// Command channel: valid/ready with the command item payload.
// ----------------------------------------------------------------------------
interface rdcc_in_if import rdcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
    logic [FIELD_BITS-1:0] point_color;
    logic [FIELD_BITS-1:0] rect_x_low;
    logic [FIELD_BITS-1:0] rect_y_low;
    logic [FIELD_BITS-1:0] rect_x_high;
    logic [FIELD_BITS-1:0] rect_y_high;

    modport source (
        output valid, cmd, point_x, point_y, point_color,
               rect_x_low, rect_y_low, rect_x_high, rect_y_high,
        input  ready
    );
    modport sink (
        input  valid, cmd, point_x, point_y, point_color,
               rect_x_low, rect_y_low, rect_x_high, rect_y_high,
        output ready
    );
endinterface

// File: rtl/core/rdcc_out_if.sv
// ----------------------------------------------------------------------------
// rdcc_out_if
// Result channel: valid/ready with the count and status payload.
// ----------------------------------------------------------------------------
interface rdcc_out_if import rdcc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OUT_COUNT_BITS-1:0] color_count;
    logic                      status;

    modport source (output valid, color_count, status, input ready);
    modport sink (input valid, color_count, status, output ready);
endinterface

// File: rtl/core/rdcc_ram.sv
// ----------------------------------------------------------------------------
// rdcc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rdcc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rdcc_seq.sv
// ----------------------------------------------------------------------------
// rdcc_seq
// Command sequencer: insertion shift and query scan over the point RAM.
// ----------------------------------------------------------------------------
module rdcc_seq import rdcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdcc_in_if.sink     i_in,
    output t_mem_req    o_mem_req,
    input  t_entry      i_rd_data,
    output t_result     o_res,
    input  logic        i_res_take,
    output t_seq_stat   o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_QRY,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_BITS-1:0]       r_count, n_count;
    logic [IDX_BITS-1:0]       r_k, n_k;
    t_entry                    r_new, n_new;
    logic [COORD_BITS-1:0]     r_xl, n_xl, r_yl, n_yl, r_xh, n_xh, r_yh, n_yh;
    logic [CNT_BITS-1:0]       r_runs, n_runs;
    logic [COLOR_BITS-1:0]     r_prev, n_prev;
    logic                      r_have_prev, n_have_prev;
    logic [OUT_COUNT_BITS-1:0] r_res_count, n_res_count;
    logic                      r_res_status, n_res_status;
    t_mem_req                  mem_req;
    logic                      hit;
    logic                      last;

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_new        = r_new;
        n_xl         = r_xl;
        n_yl         = r_yl;
        n_xh         = r_xh;
        n_yh         = r_yh;
        n_runs       = r_runs;
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        mem_req      = '0;

        hit  = (i_rd_data.x >= r_xl) && (i_rd_data.x <= r_xh) &&
               (i_rd_data.y >= r_yl) && (i_rd_data.y <= r_yh);
        last = ((CNT_BITS'(r_k) + CNT_BITS'(1)) == r_count);

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res_count  = '0;
                    n_res_status = 1'b0;
                    n_state      = S_DONE;
                    unique case (t_cmd'(i_in.cmd))
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_INSERT: begin
                            n_new.x     = i_in.point_x[COORD_BITS-1:0];
                            n_new.y     = i_in.point_y[COORD_BITS-1:0];
                            n_new.color = i_in.point_color[COLOR_BITS-1:0];
                            if (r_count >= CNT_BITS'(MAX_POINTS)) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_count = r_count + CNT_BITS'(1);
                                if (r_count == '0) begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = '0;
                                    mem_req.wdata = n_new;
                                end else begin
                                    // walk down from the top, shifting larger colors up
                                    mem_req.re    = 1'b1;
                                    mem_req.raddr = IDX_BITS'(r_count - CNT_BITS'(1));
                                    n_k           = r_count[IDX_BITS-1:0];
                                    n_state       = S_INS;
                                end
                            end
                        end
                        CMD_QUERY: begin
                            n_xl        = i_in.rect_x_low[COORD_BITS-1:0];
                            n_yl        = i_in.rect_y_low[COORD_BITS-1:0];
                            n_xh        = i_in.rect_x_high[COORD_BITS-1:0];
                            n_yh        = i_in.rect_y_high[COORD_BITS-1:0];
                            n_runs      = '0;
                            n_have_prev = 1'b0;
                            if (r_count != '0) begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = '0;
                                n_k           = '0;
                                n_state       = S_QRY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                // read data holds entry r_k-1
                if (i_rd_data.color > r_new.color) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_k;
                    mem_req.wdata = i_rd_data;
                    n_k           = r_k - IDX_BITS'(1);
                    if (r_k == IDX_BITS'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = r_k - IDX_BITS'(1) - IDX_BITS'(1);
                    end
                end else begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_k;
                    mem_req.wdata = r_new;
                    n_state       = S_DONE;
                end
            end
            S_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_k;
                mem_req.wdata = r_new;
                n_state       = S_DONE;
            end
            S_QRY: begin
                // table is color-sorted, so a new run means a new color
                if (hit && (!r_have_prev || (r_prev != i_rd_data.color))) begin
                    n_runs      = r_runs + CNT_BITS'(1);
                    n_prev      = i_rd_data.color;
                    n_have_prev = 1'b1;
                end
                if (last) begin
                    n_res_count = OUT_COUNT_BITS'(n_runs);
                    n_state     = S_DONE;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_k + IDX_BITS'(1);
                    n_k           = r_k + IDX_BITS'(1);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_k          <= n_k;
        r_new        <= n_new;
        r_xl         <= n_xl;
        r_yl         <= n_yl;
        r_xh         <= n_xh;
        r_yh         <= n_yh;
        r_runs       <= n_runs;
        r_prev       <= n_prev;
        r_have_prev  <= n_have_prev;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
    end

    assign o_mem_req    = mem_req;
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.count  = r_res_count;
    assign o_res.status = r_res_status;
    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.count = r_count;

endmodule

// File: rtl/core/rect_distinct_color_count_unit.sv
// ----------------------------------------------------------------------------
// rect_distinct_color_count_unit
// Color-sorted point table with rectangle distinct-color queries.
// ----------------------------------------------------------------------------
// Points live in one single-port-read, single-port-write RAM kept in color
// order, and every RAM access moves one entry per cycle. One item is taken at
// a time. Clear, a dropped insert (table full, status 1), a query on an empty
// table and the unused command go straight from accept to the result state.
// An insert into an empty table writes the point to slot 0 directly; into a
// non-empty table it reads down from the top, shifting each stored entry with
// a larger color up one slot on the way down, then writes the new point into
// the freed slot. A query scans every stored entry in turn. The result sits
// in an output register, so the next item is accepted while it waits to be
// taken. No clearing pass is needed after reset.
module rect_distinct_color_count_unit import rdcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdcc_in_if.sink     i_in,
    rdcc_out_if.source  o_out
);

    `include "rect_distinct_color_count_unit_assert.svh"

    t_mem_req                  mem_req;
    t_entry                    rd_data;
    t_result                   res;
    t_seq_stat                 stat;
    logic                      res_take;
    logic                      r_out_valid;
    logic [OUT_COUNT_BITS-1:0] r_out_count;
    logic                      r_out_status;

    rdcc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_mem_req  (mem_req),
        .i_rd_data  (rd_data),
        .o_res      (res),
        .i_res_take (res_take),
        .o_stat     (stat)
    );

    rdcc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    assign res_take = res.valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out_count  <= res.count;
            r_out_status <= res.status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.color_count = r_out_count;
    assign o_out.status      = r_out_status;

    `RDCC_ASSERT_NXT(a_busy_after_item, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "block took a second item before finishing the first")
    `RDCC_ASSERT_IMP(a_status_only_insert, i_clk, i_rst_n, o_out.valid && o_out.status,
        o_out.color_count == '0, "dropped insert reported a nonzero count")
    `RDCC_ASSERT_IMP(a_no_rw_collision, i_clk, i_rst_n, mem_req.we && mem_req.re,
        mem_req.waddr != mem_req.raddr, "RAM read and write hit the same entry")
    `RDCC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, stat.busy || !stat.busy,
        stat.count <= CNT_BITS'(MAX_POINTS), "point count above table depth")

endmodule
